// ===== rtl/core/bsc_pkg.sv =====
// ============================================================================
// bsc_pkg
// Shared constants, types and lookup functions for the six-step commutator.
// ============================================================================
package bsc_pkg;

  // Angle scale: 1/64 degree, one mechanical turn
  localparam int ANGLE_FULL_TURN = 23040;
  localparam int ANGLE_HALF_TURN = ANGLE_FULL_TURN / 2;

  // Duty scale and saturation ceiling (10-bit result field)
  localparam int DUTY_FULL_SCALE = 1024;
  localparam int DUTY_MAX = (DUTY_FULL_SCALE - 1 > 1023) ? 1023 : DUTY_FULL_SCALE - 1;

  // Field widths
  localparam int ANGLE_W   = 15;
  localparam int CUR_W     = 16;
  localparam int CMD_W     = 16;
  localparam int POLE_W    = 6;
  localparam int GAIN_W    = 16;
  localparam int SECTOR_W  = 3;
  localparam int MASK_W    = 3;
  localparam int DUTY_W    = 10;
  localparam int PROD_W    = ANGLE_W + POLE_W;
  localparam int TWELFTH_W = 10;   // twelfth-turn count of the electrical product

  // One twelfth of a turn is 1920 = 15 << 7: shift, then divide by 15 with
  // a reciprocal multiply (exact for the 14-bit shifted product)
  localparam int TWELFTH_SHIFT = 7;
  localparam int DIV15_MUL     = 17477;
  localparam int DIV15_SHIFT   = 18;
  localparam int SHIFTED_W     = PROD_W - TWELFTH_SHIFT;

  // Configuration register map
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_CALIB_OFFSET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_OFFSET  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POLE_PAIRS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_GAIN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_ORDER   = 3'd5;

  // Step direction codes
  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_FWD  = 2'd1;
  localparam logic [1:0] STEP_BWD  = 2'd2;

  // Phase bits
  localparam logic [MASK_W-1:0] PH_U = 3'b001;
  localparam logic [MASK_W-1:0] PH_V = 3'b010;
  localparam logic [MASK_W-1:0] PH_W = 3'b100;

  typedef struct packed {
    logic [ANGLE_W-1:0] pos_offset;
    logic [ANGLE_W-1:0] elec_offset;
    logic [POLE_W-1:0]  pole_pairs;
    logic [ANGLE_W-2:0] voltage_limit_hi;  // upper bits of the 15-bit limit
    logic               voltage_limit_lo;
    logic [GAIN_W-1:0]  duty_gain;
    logic               phase_order;
  } cfg_t;

  typedef struct packed {
    logic [SECTOR_W-1:0]    sector;
    logic [MASK_W-1:0]      hi_mask;
    logic [MASK_W-1:0]      lo_mask;
    logic signed [CUR_W-1:0] dc_current;
    logic [1:0]             step_rule;
  } comm_t;

  // Negation that saturates the most negative code
  function automatic logic signed [CUR_W-1:0] neg_sat16(input logic signed [CUR_W-1:0] x);
    logic signed [CUR_W-1:0] r;
    if (x == {1'b1, {(CUR_W-1){1'b0}}}) begin
      r = {1'b0, {(CUR_W-1){1'b1}}};
    end else begin
      r = -x;
    end
    return r;
  endfunction

  // Commutation table: {high side, low side} for a sector index 0..5
  function automatic logic [2*MASK_W-1:0] phase_pair(input logic [SECTOR_W-1:0] idx,
                                                     input logic cw);
    logic [2*MASK_W-1:0] r;
    if (cw) begin
      case (idx)
        3'd0:    r = {PH_U, PH_W};
        3'd1:    r = {PH_U, PH_V};
        3'd2:    r = {PH_W, PH_V};
        3'd3:    r = {PH_W, PH_U};
        3'd4:    r = {PH_V, PH_U};
        3'd5:    r = {PH_V, PH_W};
        default: r = '0;
      endcase
    end else begin
      case (idx)
        3'd0:    r = {PH_U, PH_V};
        3'd1:    r = {PH_U, PH_W};
        3'd2:    r = {PH_V, PH_W};
        3'd3:    r = {PH_V, PH_U};
        3'd4:    r = {PH_W, PH_U};
        3'd5:    r = {PH_W, PH_V};
        default: r = '0;
      endcase
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/bsc_if.sv =====
// ============================================================================
// bsc_if
// Valid/ready channels of the commutator: control tick, result, config write.
// ============================================================================
interface bsc_item_if;
  import bsc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [ANGLE_W-1:0]       mech_angle;
  logic signed [CUR_W-1:0]  phase_a_current;
  logic signed [CUR_W-1:0]  phase_b_current;
  logic signed [CUR_W-1:0]  phase_c_current;
  logic signed [CMD_W-1:0]  voltage_ref;
  logic                     fault;

  modport source (output valid, mech_angle, phase_a_current, phase_b_current,
                  phase_c_current, voltage_ref, fault, input ready);
  modport sink   (input valid, mech_angle, phase_a_current, phase_b_current,
                  phase_c_current, voltage_ref, fault, output ready);
endinterface

interface bsc_res_if;
  import bsc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [SECTOR_W-1:0]      sector;
  logic signed [ANGLE_W-1:0] position;
  logic [MASK_W-1:0]        pwm_phase_mask;
  logic [MASK_W-1:0]        low_side_mask;
  logic [DUTY_W-1:0]        duty;
  logic signed [CUR_W-1:0]  dc_current;

  modport source (output valid, sector, position, pwm_phase_mask, low_side_mask,
                  duty, dc_current, input ready);
  modport sink   (input valid, sector, position, pwm_phase_mask, low_side_mask,
                  duty, dc_current, output ready);
endinterface

interface bsc_cfg_if;
  import bsc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/bsc_cfg_regs.sv =====
// ============================================================================
// bsc_cfg_regs
// Configuration register file; writes to unmapped indexes are dropped.
// ============================================================================
module bsc_cfg_regs (
  input  logic         clk_i,
  input  logic         rst_ni,
  bsc_cfg_if.sink      cfg_if,
  output bsc_pkg::cfg_t cfg_o
);
  import bsc_pkg::*;

  cfg_t cfg_q;
  logic wr_en;

  // always able to take a write beat
  assign cfg_if.ready = 1'b1;
  assign wr_en        = cfg_if.valid & cfg_if.ready;
  assign cfg_o        = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_offset       <= '0;
      cfg_q.elec_offset      <= '0;
      cfg_q.pole_pairs       <= POLE_W'(1);
      cfg_q.voltage_limit_hi <= '1;
      cfg_q.voltage_limit_lo <= 1'b1;
      cfg_q.duty_gain        <= GAIN_W'(32768);
      cfg_q.phase_order      <= 1'b0;
    end else if (wr_en) begin
      case (cfg_if.index)
        CFG_CALIB_OFFSET:  cfg_q.pos_offset  <= cfg_if.data[ANGLE_W-1:0];
        CFG_ALIGN_OFFSET:  cfg_q.elec_offset <= cfg_if.data[ANGLE_W-1:0];
        CFG_POLE_PAIRS:    cfg_q.pole_pairs  <= cfg_if.data[POLE_W-1:0];
        CFG_VOLTAGE_LIMIT: begin
          cfg_q.voltage_limit_hi <= cfg_if.data[ANGLE_W-1:1];
          cfg_q.voltage_limit_lo <= cfg_if.data[0];
        end
        CFG_DUTY_GAIN:     cfg_q.duty_gain   <= cfg_if.data[GAIN_W-1:0];
        CFG_PHASE_ORDER:   cfg_q.phase_order <= cfg_if.data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/bsc_commutate.sv =====
// ============================================================================
// bsc_commutate
// Sector decode from the twelfth-turn count, step direction, DC-link current
// pick and commutation table lookup.
// ============================================================================
module bsc_commutate (
  input  logic [bsc_pkg::TWELFTH_W-1:0] twelfth_i,
  input  logic [bsc_pkg::SECTOR_W-1:0]  prev_sector_i,
  input  logic [1:0]                    step_rule_i,
  input  logic signed [bsc_pkg::CUR_W-1:0] ia_i,
  input  logic signed [bsc_pkg::CUR_W-1:0] ib_i,
  input  logic signed [bsc_pkg::CUR_W-1:0] ic_i,
  input  logic                          reverse_i,
  input  logic                          phase_order_i,
  output bsc_pkg::comm_t                comm_o
);
  import bsc_pkg::*;

  logic [7:0]            quarter;
  logic [15:0]           div3_prod;
  logic [6:0]            turns;
  logic [TWELFTH_W-1:0]  rem_full;
  logic [3:0]            twelfth_mod;
  logic [SECTOR_W-1:0]   sector;
  logic [SECTOR_W-1:0]   idx;
  logic signed [3:0]     diff;
  logic signed [3:0]     diff_wrap;
  logic [1:0]            rule_next;
  logic signed [CUR_W-1:0] idc;
  logic [2*MASK_W-1:0]   pair;

  // twelfth count mod 12: divide by 12 as (>>2) then /3 by reciprocal
  always_comb begin
    quarter     = twelfth_i[TWELFTH_W-1:2];
    div3_prod   = 16'(quarter) * 16'd171;
    turns       = div3_prod[15:9];
    rem_full    = twelfth_i - TWELFTH_W'({turns, 3'b000}) - TWELFTH_W'({turns, 2'b00});
    twelfth_mod = rem_full[3:0];
  end

  // sector 6 straddles zero; others cover two twelfths each
  always_comb begin
    logic [3:0] up;
    up = twelfth_mod + 4'd1;
    if (twelfth_mod == 4'd0 || twelfth_mod == 4'd11) begin
      sector = 3'd6;
    end else begin
      sector = up[3:1];
    end
  end

  // step direction, wrapped into -3..3
  always_comb begin
    diff = $signed({1'b0, sector}) - $signed({1'b0, prev_sector_i});
    if (diff > 4'sd3) begin
      diff_wrap = diff - 4'sd6;
    end else if (diff < -4'sd3) begin
      diff_wrap = diff + 4'sd6;
    end else begin
      diff_wrap = diff;
    end
    if (diff_wrap > 4'sd0) begin
      rule_next = STEP_FWD;
    end else if (diff_wrap < 4'sd0) begin
      rule_next = STEP_BWD;
    end else begin
      rule_next = step_rule_i;
    end
  end

  // DC-link current from the phase that carries it in this step
  always_comb begin
    idc = '0;
    case (rule_next)
      STEP_FWD: begin
        case (sector)
          3'd1:    idc = neg_sat16(ib_i);
          3'd2:    idc = ia_i;
          3'd3:    idc = neg_sat16(ic_i);
          3'd4:    idc = ib_i;
          3'd5:    idc = neg_sat16(ia_i);
          default: idc = ic_i;
        endcase
      end
      STEP_BWD: begin
        case (sector)
          3'd1:    idc = ia_i;
          3'd2:    idc = neg_sat16(ic_i);
          3'd3:    idc = ib_i;
          3'd4:    idc = neg_sat16(ia_i);
          3'd5:    idc = ic_i;
          default: idc = neg_sat16(ib_i);
        endcase
      end
      default: idc = '0;
    endcase
  end

  // table lookup, pair swapped for a negative command
  always_comb begin
    idx  = sector - 3'd1;
    pair = phase_pair(idx, phase_order_i);
    comm_o.sector     = sector;
    comm_o.dc_current = idc;
    comm_o.step_rule  = rule_next;
    if (reverse_i) begin
      comm_o.hi_mask = pair[MASK_W-1:0];
      comm_o.lo_mask = pair[2*MASK_W-1:MASK_W];
    end else begin
      comm_o.hi_mask = pair[2*MASK_W-1:MASK_W];
      comm_o.lo_mask = pair[MASK_W-1:0];
    end
  end

endmodule

// ===== rtl/core/bldc_six_step_commutator.sv =====
// ============================================================================
// bldc_six_step_commutator
// Six-step BLDC commutation: position wrap, sector decode, DC-link current,
// duty scaling and phase selection for each control tick.
// ============================================================================
// A tick beat is accepted in any cycle in which the result side is not
// stalled, so the block sustains one tick per clock. Each tick passes an
// input register, two arithmetic stages and the result register, in that
// order. The two stages exist because the electrical-angle product (angle
// times pole pairs) and the twelfth-turn reciprocal multiply each get a
// register of their own. The step direction state updates as a tick enters
// the result register, in tick order. Config writes are taken at any time
// but must only be issued while idle.
module bldc_six_step_commutator (
  input  logic    clk_i,
  input  logic    rst_ni,
  bsc_item_if.sink  in_if,
  bsc_res_if.source out_if,
  bsc_cfg_if.sink   cfg_if
);
  import bsc_pkg::*;

  localparam logic signed [17:0] FULL_S = 18'(ANGLE_FULL_TURN);
  localparam logic signed [17:0] HALF_S = 18'(ANGLE_HALF_TURN);
  localparam logic signed [17:0] POS_MAX_S = 18'(2**(ANGLE_W-1) - 1);
  localparam logic signed [17:0] POS_MIN_S = -18'(2**(ANGLE_W-1));

  cfg_t cfg;
  logic [ANGLE_W-1:0] voltage_limit;
  logic               adv;

  // stage 1: input register
  logic                    s1_valid_q;
  logic [ANGLE_W-1:0]      s1_mech_q;
  logic signed [CUR_W-1:0] s1_ia_q, s1_ib_q, s1_ic_q;
  logic signed [CMD_W-1:0] s1_vref_q;
  logic                    s1_fault_q;

  // stage 2
  logic                     s2_valid_q;
  logic signed [ANGLE_W-1:0] s2_pos_q, s2_pos_d;
  logic [PROD_W-1:0]        s2_prod_q, s2_prod_d;
  logic [ANGLE_W-1:0]       s2_mag_q, s2_mag_d;
  logic                     s2_rev_q, s2_rev_d;
  logic signed [CUR_W-1:0]  s2_ia_q, s2_ib_q, s2_ic_q;
  logic                     s2_fault_q;

  // stage 3
  logic                     s3_valid_q;
  logic signed [ANGLE_W-1:0] s3_pos_q;
  logic [TWELFTH_W-1:0]     s3_twelfth_q, s3_twelfth_d;
  logic [DUTY_W-1:0]        s3_duty_q, s3_duty_d;
  logic                     s3_rev_q;
  logic signed [CUR_W-1:0]  s3_ia_q, s3_ib_q, s3_ic_q;
  logic                     s3_fault_q;

  // result register and direction state
  logic                     out_valid_q;
  logic [SECTOR_W-1:0]      sector_q;
  logic signed [ANGLE_W-1:0] position_q;
  logic [MASK_W-1:0]        pwm_mask_q, low_mask_q;
  logic [DUTY_W-1:0]        duty_q;
  logic signed [CUR_W-1:0]  dc_current_q;
  logic [SECTOR_W-1:0]      prev_sector_q;
  logic [1:0]               step_rule_q;
  comm_t                    comm;

  bsc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_if (cfg_if),
    .cfg_o  (cfg)
  );

  assign voltage_limit = {cfg.voltage_limit_hi, cfg.voltage_limit_lo};

  // whole pipe moves when the result register is free or being taken
  assign adv         = !out_valid_q || out_if.ready;
  assign in_if.ready = adv;

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= in_if.valid;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_mech_q  <= in_if.mech_angle;
      s1_ia_q    <= in_if.phase_a_current;
      s1_ib_q    <= in_if.phase_b_current;
      s1_ic_q    <= in_if.phase_c_current;
      s1_vref_q  <= in_if.voltage_ref;
      s1_fault_q <= in_if.fault;
    end
  end

  // position wrap to half a turn, then saturate
  always_comb begin
    logic signed [17:0] cal;
    logic signed [17:0] wrapped;
    cal = $signed({3'b000, s1_mech_q}) - $signed({3'b000, cfg.pos_offset});
    if (cal > HALF_S) begin
      wrapped = cal - FULL_S;
    end else if (cal < -HALF_S) begin
      wrapped = cal + FULL_S;
    end else begin
      wrapped = cal;
    end
    if (wrapped > POS_MAX_S) begin
      s2_pos_d = POS_MAX_S[ANGLE_W-1:0];
    end else if (wrapped < POS_MIN_S) begin
      s2_pos_d = POS_MIN_S[ANGLE_W-1:0];
    end else begin
      s2_pos_d = wrapped[ANGLE_W-1:0];
    end
  end

  // aligned angle reduced into one turn, times pole pairs
  always_comb begin
    logic signed [17:0] al;
    logic signed [17:0] al_p1;
    logic signed [17:0] al_p2;
    logic signed [17:0] al_m1;
    logic signed [17:0] al_sel;
    al    = $signed({3'b000, s1_mech_q}) - $signed({3'b000, cfg.elec_offset});
    al_p1 = al + FULL_S;
    al_p2 = al_p1 + FULL_S;
    al_m1 = al - FULL_S;
    if (al < 18'sd0) begin
      al_sel = (al_p1 < 18'sd0) ? al_p2 : al_p1;
    end else if (al >= FULL_S) begin
      al_sel = al_m1;
    end else begin
      al_sel = al;
    end
    s2_prod_d = PROD_W'(al_sel[ANGLE_W-1:0]) * PROD_W'(cfg.pole_pairs);
  end

  // command clamp: magnitude and direction
  always_comb begin
    logic [CMD_W:0] vabs;
    if (s1_vref_q[CMD_W-1]) begin
      vabs = (CMD_W+1)'(-$signed({s1_vref_q[CMD_W-1], s1_vref_q}));
    end else begin
      vabs = {1'b0, s1_vref_q};
    end
    if (vabs > (CMD_W+1)'(voltage_limit)) begin
      s2_mag_d = voltage_limit;
    end else begin
      s2_mag_d = vabs[ANGLE_W-1:0];
    end
    s2_rev_d = s1_vref_q[CMD_W-1] && (voltage_limit != '0);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_pos_q   <= s2_pos_d;
      s2_prod_q  <= s2_prod_d;
      s2_mag_q   <= s2_mag_d;
      s2_rev_q   <= s2_rev_d;
      s2_ia_q    <= s1_ia_q;
      s2_ib_q    <= s1_ib_q;
      s2_ic_q    <= s1_ic_q;
      s2_fault_q <= s1_fault_q;
    end
  end

  // twelfth-turn count of the product, and duty scaling with saturation
  always_comb begin
    logic [SHIFTED_W+15-1:0] recip;
    logic [ANGLE_W+GAIN_W-1:0] dprod;
    logic [ANGLE_W-1:0]        dscaled;
    recip = (SHIFTED_W+15)'(s2_prod_q[PROD_W-1:TWELFTH_SHIFT]) * (SHIFTED_W+15)'(DIV15_MUL);
    s3_twelfth_d = recip[DIV15_SHIFT +: TWELFTH_W];
    dprod   = (ANGLE_W+GAIN_W)'(s2_mag_q) * (ANGLE_W+GAIN_W)'(cfg.duty_gain);
    dscaled = dprod[ANGLE_W+GAIN_W-1:16];
    if (dscaled > ANGLE_W'(DUTY_MAX)) begin
      s3_duty_d = DUTY_W'(DUTY_MAX);
    end else begin
      s3_duty_d = dscaled[DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_pos_q     <= s2_pos_q;
      s3_twelfth_q <= s3_twelfth_d;
      s3_duty_q    <= s3_duty_d;
      s3_rev_q     <= s2_rev_q;
      s3_ia_q      <= s2_ia_q;
      s3_ib_q      <= s2_ib_q;
      s3_ic_q      <= s2_ic_q;
      s3_fault_q   <= s2_fault_q;
    end
  end

  bsc_commutate u_comm (
    .twelfth_i     (s3_twelfth_q),
    .prev_sector_i (prev_sector_q),
    .step_rule_i   (step_rule_q),
    .ia_i          (s3_ia_q),
    .ib_i          (s3_ib_q),
    .ic_i          (s3_ic_q),
    .reverse_i     (s3_rev_q),
    .phase_order_i (cfg.phase_order),
    .comm_o        (comm)
  );

  // direction state follows ticks as they reach the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_sector_q <= '0;
      step_rule_q   <= STEP_NONE;
    end else if (adv && s3_valid_q) begin
      prev_sector_q <= comm.sector;
      step_rule_q   <= comm.step_rule;
    end
  end

  // result register; a fault drops all switches and duty
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sector_q     <= comm.sector;
      position_q   <= s3_pos_q;
      dc_current_q <= comm.dc_current;
      pwm_mask_q   <= s3_fault_q ? '0 : comm.hi_mask;
      low_mask_q   <= s3_fault_q ? '0 : comm.lo_mask;
      duty_q       <= s3_fault_q ? '0 : s3_duty_q;
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.sector         = sector_q;
  assign out_if.position       = position_q;
  assign out_if.pwm_phase_mask = pwm_mask_q;
  assign out_if.low_side_mask  = low_mask_q;
  assign out_if.duty           = duty_q;
  assign out_if.dc_current     = dc_current_q;

`ifndef SYNTH
  a_sector_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (sector_q != 3'd0 && sector_q != 3'd7))
    else $error("sector out of range");

  a_masks_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ($onehot0(pwm_mask_q) && $onehot0(low_mask_q) &&
                     (pwm_mask_q & low_mask_q) == '0))
    else $error("high and low side drive overlap");

  a_duty_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (duty_q <= DUTY_W'(DUTY_MAX)))
    else $error("duty above saturation");

  a_rule_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_rule_q != STEP_NONE) |=> (step_rule_q != STEP_NONE))
    else $error("step direction lost");

  a_rule_has_prev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_rule_q != STEP_NONE) |-> (prev_sector_q != '0))
    else $error("direction set without a previous sector");
`endif

endmodule

// ===== tb/sv/bldc_six_step_commutator_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// bldc_six_step_commutator_tb
// Self-checking bench for the six-step commutator. A queue of control ticks
// is first filled with directed cases and then with phases of random rotor
// motion, and a driver feeds the queue into the tick channel. A behavioral
// predictor keeps its own copy of the registers and of the step direction,
// and it computes the expected result of each accepted tick. A monitor
// compares every result beat with the oldest prediction, field by field.
// Registers are rewritten between phases while the block is idle.
// ============================================================================
module bldc_six_step_commutator_tb;
  import bsc_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 7;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_PHASES     = 8;
  localparam int TICKS_PER_PH   = 212;
  localparam int CUR_MIN        = -32768;
  localparam int CUR_MAX        = 32767;

  // Register indexes outside the map; writes to them must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  // Commutation tables, sector index 0 in the low bits
  localparam logic [6*MASK_W-1:0] CCW_HI = {PH_W, PH_W, PH_V, PH_V, PH_U, PH_U};
  localparam logic [6*MASK_W-1:0] CCW_LO = {PH_V, PH_U, PH_U, PH_W, PH_W, PH_V};
  localparam logic [6*MASK_W-1:0] CW_HI  = {PH_V, PH_V, PH_W, PH_W, PH_U, PH_U};
  localparam logic [6*MASK_W-1:0] CW_LO  = {PH_W, PH_U, PH_U, PH_V, PH_V, PH_W};

  typedef struct {
    logic [ANGLE_W-1:0]      mech;
    logic signed [CUR_W-1:0] ia;
    logic signed [CUR_W-1:0] ib;
    logic signed [CUR_W-1:0] ic;
    logic signed [CMD_W-1:0] vref;
    logic                    fault;
  } tick_t;

  typedef struct {
    logic [SECTOR_W-1:0]       sector;
    logic signed [ANGLE_W-1:0] position;
    logic [MASK_W-1:0]         hi_mask;
    logic [MASK_W-1:0]         lo_mask;
    logic [DUTY_W-1:0]         duty;
    logic signed [CUR_W-1:0]   dc;
  } drive_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bsc_item_if tick_if ();
  bsc_res_if  res_if ();
  bsc_cfg_if  wr_if ();

  bldc_six_step_commutator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (tick_if),
    .out_if (res_if),
    .cfg_if (wr_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Register shadow and commutation state of the predictor
  int         cal_off   = 0;
  int         aln_off   = 0;
  int         pole_cnt  = 1;
  int         v_lim     = 32767;
  int         d_gain    = 32768;
  logic       cw_order  = 1'b0;
  int         last_sector = 0;
  logic [1:0] step_dir  = STEP_NONE;

  tick_t  pending_ticks[$];
  drive_t due_drives[$];
  tick_t  seen_tick;
  drive_t want;

  int   err_cnt      = 0;
  int   idle_cycles  = 0;
  int   tick_idle_pct = 0;
  int   res_idle_pct  = 0;
  int   tick_gap     = 0;
  int   res_stall    = 0;
  logic tick_taken   = 1'b0;
  int   rotor_ang    = 0;
  int   rotor_step   = 100;

  function automatic int neg_clip(int x);
    return (x == CUR_MIN) ? CUR_MAX : -x;
  endfunction

  // Predict one tick and advance the step-direction state
  function automatic drive_t commutate(tick_t t);
    drive_t r;
    int cal, a, sec, delta, vr, mag, idx, dc, ia, ib, ic;
    longint e, tw, duty;
    logic [MASK_W-1:0] hi, lo, sw;
    ia = int'(t.ia);
    ib = int'(t.ib);
    ic = int'(t.ic);
    vr = int'(t.vref);

    // position wrap to half a turn, then 15-bit saturation
    cal = int'(t.mech) - cal_off;
    if (cal > ANGLE_HALF_TURN) cal -= ANGLE_FULL_TURN;
    else if (cal < -ANGLE_HALF_TURN) cal += ANGLE_FULL_TURN;
    if (cal > 16383) cal = 16383;
    if (cal < -16384) cal = -16384;

    // electrical angle and sector
    a = (int'(t.mech) - aln_off) % ANGLE_FULL_TURN;
    if (a < 0) a += ANGLE_FULL_TURN;
    e = (longint'(a) * pole_cnt) % ANGLE_FULL_TURN;
    tw = e * 12;
    if (tw < ANGLE_FULL_TURN || tw >= 11 * ANGLE_FULL_TURN) sec = 6;
    else sec = int'((tw + ANGLE_FULL_TURN) / (2 * ANGLE_FULL_TURN));

    // step direction from the sector change, wrapped by six
    delta = sec - last_sector;
    last_sector = sec;
    if (delta > 3) delta -= 6;
    else if (delta < -3) delta += 6;
    if (delta > 0) step_dir = STEP_FWD;
    else if (delta < 0) step_dir = STEP_BWD;

    // DC-link current pick
    dc = 0;
    if (step_dir == STEP_FWD) begin
      case (sec)
        1: dc = neg_clip(ib);
        2: dc = ia;
        3: dc = neg_clip(ic);
        4: dc = ib;
        5: dc = neg_clip(ia);
        default: dc = ic;
      endcase
    end else if (step_dir == STEP_BWD) begin
      case (sec)
        1: dc = ia;
        2: dc = neg_clip(ic);
        3: dc = ib;
        4: dc = neg_clip(ia);
        5: dc = ic;
        default: dc = neg_clip(ib);
      endcase
    end

    // clamp and duty
    if (vr > v_lim) vr = v_lim;
    if (vr < -v_lim) vr = -v_lim;
    mag = (vr < 0) ? -vr : vr;
    duty = (longint'(mag) * d_gain) >>> 16;
    if (duty > DUTY_MAX) duty = DUTY_MAX;

    // phase pair, swapped for a negative command
    idx = sec - 1;
    hi = cw_order ? CW_HI[idx*MASK_W +: MASK_W] : CCW_HI[idx*MASK_W +: MASK_W];
    lo = cw_order ? CW_LO[idx*MASK_W +: MASK_W] : CCW_LO[idx*MASK_W +: MASK_W];
    if (vr < 0) begin
      sw = hi;
      hi = lo;
      lo = sw;
    end
    if (t.fault) begin
      hi = '0;
      lo = '0;
      duty = 0;
    end

    r.sector   = sec[SECTOR_W-1:0];
    r.position = cal[ANGLE_W-1:0];
    r.hi_mask  = hi;
    r.lo_mask  = lo;
    r.duty     = duty[DUTY_W-1:0];
    r.dc       = dc[CUR_W-1:0];
    return r;
  endfunction

  function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_CALIB_OFFSET:  cal_off  = int'(val[ANGLE_W-1:0]);
      CFG_ALIGN_OFFSET:  aln_off  = int'(val[ANGLE_W-1:0]);
      CFG_POLE_PAIRS:    pole_cnt = int'(val[POLE_W-1:0]);
      CFG_VOLTAGE_LIMIT: v_lim    = int'(val[ANGLE_W-1:0]);
      CFG_DUTY_GAIN:     d_gain   = int'(val);
      CFG_PHASE_ORDER:   cw_order = val[0];
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic signed [31:0] expv,
                                      logic signed [31:0] gotv);
    if (gotv !== expv) begin
      $error("%s: expected %0d, got %0d", name, expv, gotv);
      err_cnt++;
    end
  endfunction

  function automatic logic signed [CUR_W-1:0] any_current();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return CUR_W'(CUR_MIN);
    if (r < 12) return CUR_W'(CUR_MAX);
    if (r < 16) return '0;
    return CUR_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic signed [CMD_W-1:0] any_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return CMD_W'(CUR_MIN);
    if (r < 12) return CMD_W'(CUR_MAX);
    if (r < 17) return '0;
    if (r < 27) return CMD_W'(($urandom_range(0, 1) ? v_lim : -v_lim) + $urandom_range(0, 2) - 1);
    if (r < 50) return CMD_W'($urandom_range(0, 4095) - 2048);
    return CMD_W'($urandom_range(0, 65535));
  endfunction

  // Rotor that mostly turns steadily, with reversals and jumps
  function automatic tick_t random_tick();
    tick_t t;
    if ($urandom_range(0, 99) < 12) begin
      rotor_ang = $urandom_range(0, ANGLE_FULL_TURN - 1);
    end else begin
      if ($urandom_range(0, 29) == 0) rotor_step = -rotor_step;
      rotor_ang = (rotor_ang + rotor_step + ANGLE_FULL_TURN) % ANGLE_FULL_TURN;
    end
    t.mech  = ANGLE_W'(rotor_ang);
    t.ia    = any_current();
    t.ib    = any_current();
    t.ic    = any_current();
    t.vref  = any_command();
    t.fault = ($urandom_range(0, 19) == 0);
    return t;
  endfunction

  task automatic push_tick(int mech, int ia, int ib, int ic, int vref, logic fault);
    tick_t t;
    t.mech  = ANGLE_W'(mech);
    t.ia    = CUR_W'(ia);
    t.ib    = CUR_W'(ib);
    t.ic    = CUR_W'(ic);
    t.vref  = CMD_W'(vref);
    t.fault = fault;
    pending_ticks.push_back(t);
  endtask

  // Register write beat; valid stays up until the caller drops it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    wr_if.valid <= 1'b1;
    wr_if.index <= idx;
    wr_if.data  <= val;
    do @(posedge clk_i); while (!wr_if.ready);
    apply_write(idx, val);
  endtask

  task automatic settle();
    while (pending_ticks.size() != 0 || due_drives.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Tick driver: holds a beat until accepted, random gaps between beats
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!tick_if.valid || tick_taken) begin
        if (tick_gap != 0) begin
          tick_gap--;
          tick_if.valid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          tick_if.valid           <= 1'b1;
          tick_if.mech_angle      <= pending_ticks[0].mech;
          tick_if.phase_a_current <= pending_ticks[0].ia;
          tick_if.phase_b_current <= pending_ticks[0].ib;
          tick_if.phase_c_current <= pending_ticks[0].ic;
          tick_if.voltage_ref     <= pending_ticks[0].vref;
          tick_if.fault           <= pending_ticks[0].fault;
          if ($urandom_range(0, 99) < tick_idle_pct) tick_gap = $urandom_range(1, 18);
        end else begin
          tick_if.valid <= 1'b0;
        end
      end
      tick_taken = 1'b0;
    end
  end

  // Result-side backpressure in bursts
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (res_stall != 0) begin
        res_stall--;
        res_if.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < res_idle_pct) begin
        res_stall = $urandom_range(1, 18) - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Accepted tick beat: predict its result
  always @(posedge clk_i) begin
    if (rst_ni && tick_if.valid && tick_if.ready) begin
      seen_tick.mech  = tick_if.mech_angle;
      seen_tick.ia    = tick_if.phase_a_current;
      seen_tick.ib    = tick_if.phase_b_current;
      seen_tick.ic    = tick_if.phase_c_current;
      seen_tick.vref  = tick_if.voltage_ref;
      seen_tick.fault = tick_if.fault;
      due_drives.push_back(commutate(seen_tick));
      void'(pending_ticks.pop_front());
      tick_taken = 1'b1;
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (due_drives.size() == 0) begin
        $error("result beat with no tick outstanding");
        err_cnt++;
      end else begin
        want = due_drives.pop_front();
        check_field("sector", 32'(want.sector), 32'(res_if.sector));
        check_field("position", 32'(want.position), 32'(res_if.position));
        check_field("pwm_phase_mask", 32'(want.hi_mask), 32'(res_if.pwm_phase_mask));
        check_field("low_side_mask", 32'(want.lo_mask), 32'(res_if.low_side_mask));
        check_field("duty", 32'(want.duty), 32'(res_if.duty));
        check_field("dc_current", 32'(want.dc), 32'(res_if.dc_current));
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((tick_if.valid && tick_if.ready) || (res_if.valid && res_if.ready) ||
        (wr_if.valid && wr_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    int c_cal, c_aln, c_pp, c_lim, c_gain, c_ord;
    rst_ni                  = 1'b0;
    tick_if.valid           = 1'b0;
    tick_if.mech_angle      = '0;
    tick_if.phase_a_current = '0;
    tick_if.phase_b_current = '0;
    tick_if.phase_c_current = '0;
    tick_if.voltage_ref     = '0;
    tick_if.fault           = 1'b0;
    res_if.ready            = 1'b0;
    wr_if.valid             = 1'b0;
    wr_if.index             = '0;
    wr_if.data              = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed ticks on reset registers
    tick_idle_pct = 15;
    res_idle_pct  = 15;
    // sector 6 straight after reset: no direction yet, zero command
    push_tick(0, CUR_MIN, CUR_MIN, CUR_MIN, 0, 1'b0);
    // forward sweep, saturating negation on the negated phases
    for (int k = 1; k <= 6; k++) begin
      push_tick((3840 * k) % ANGLE_FULL_TURN, CUR_MIN, CUR_MIN, CUR_MIN,
                (k % 3 == 0) ? 0 : ((k % 3 == 1) ? CUR_MAX : CUR_MIN), 1'b0);
    end
    // same sector again keeps the direction
    push_tick(0, CUR_MAX, CUR_MAX, CUR_MAX, -1, 1'b0);
    // backward sweep
    for (int k = 5; k >= 1; k--) push_tick(3840 * k, CUR_MIN, CUR_MIN, CUR_MIN, CUR_MIN, 1'b0);
    push_tick(0, CUR_MIN, CUR_MIN, CUR_MIN, 1, 1'b0);
    // half-turn jumps in both directions
    push_tick(3 * 3840, 123, -456, 789, 300, 1'b0);
    push_tick(0, -1000, 2000, -3000, -300, 1'b0);
    // sector edges and the largest angle, with a fault
    push_tick(1919, 1, 2, 3, 5000, 1'b0);
    push_tick(1920, 4, 5, 6, -5000, 1'b0);
    push_tick(21119, 7, 8, 9, CUR_MAX, 1'b0);
    push_tick(21120, 10, 11, 12, CUR_MAX, 1'b0);
    push_tick(ANGLE_FULL_TURN - 1, CUR_MAX, CUR_MIN, 0, CUR_MAX, 1'b1);
    push_tick(ANGLE_HALF_TURN, 0, 0, 0, CUR_MIN, 1'b1);
    settle();

    // Random phases, each with its own register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      c_cal  = $urandom_range(0, ANGLE_FULL_TURN - 1);
      c_aln  = $urandom_range(0, ANGLE_FULL_TURN - 1);
      c_pp   = $urandom_range(1, 32);
      c_lim  = $urandom_range(0, 32767);
      c_gain = $urandom_range(0, 65535);
      c_ord  = $urandom_range(0, 1);
      case (ph)
        0: begin
          c_cal = 0; c_aln = 0; c_pp = 1; c_lim = 32767; c_gain = 65535; c_ord = 1;
        end
        1: begin
          c_cal = ANGLE_FULL_TURN - 1; c_aln = ANGLE_FULL_TURN - 1; c_pp = 32;
          c_lim = 0; c_gain = 0; c_ord = 0;
        end
        // zero pole pairs pins the sector to 6
        2: begin
          c_pp = 0; c_ord = 1;
        end
        3: begin
          c_pp = 32; c_lim = 1; c_gain = 65535; c_ord = 0;
        end
        4: begin
          c_gain = $urandom_range(512, 4096);
        end
        default: ;
      endcase
      write_reg(CFG_CALIB_OFFSET, CFG_DATA_W'(c_cal | ($urandom_range(0, 1) << ANGLE_W)));
      write_reg(CFG_ALIGN_OFFSET, CFG_DATA_W'(c_aln | ($urandom_range(0, 1) << ANGLE_W)));
      write_reg(CFG_POLE_PAIRS, CFG_DATA_W'(c_pp | ($urandom_range(0, 1023) << POLE_W)));
      write_reg(CFG_VOLTAGE_LIMIT, CFG_DATA_W'(c_lim | ($urandom_range(0, 1) << ANGLE_W)));
      write_reg(CFG_DUTY_GAIN, CFG_DATA_W'(c_gain));
      write_reg(CFG_PHASE_ORDER, CFG_DATA_W'(c_ord | ($urandom_range(0, 32767) << 1)));
      if (ph == 1) write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom_range(0, 65535)));
      if (ph == 4) write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom_range(0, 65535)));
      @(negedge clk_i);
      wr_if.valid <= 1'b0;

      // step small enough that sectors mostly walk one at a time
      rotor_step = $urandom_range(1, 3000 / ((pole_cnt == 0) ? 1 : pole_cnt));
      if ($urandom_range(0, 1)) rotor_step = -rotor_step;
      if (ph == NUM_PHASES - 1) begin
        tick_idle_pct = 0;
        res_idle_pct  = 0;
      end else begin
        tick_idle_pct = (ph % 3 == 2) ? 0 : $urandom_range(5, 40);
        res_idle_pct  = (ph % 3 == 1) ? 0 : $urandom_range(5, 40);
      end
      for (int n = 0; n < TICKS_PER_PH; n++) pending_ticks.push_back(random_tick());
      settle();
    end

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
